FILE: design/pxa_pkg.sv
// ----------------------------------------------------------------------------
// pxa_pkg
// Shared types and constants of the Paxos acceptor: field widths, request
// kind codes, the controller command and status groups and the result record.
// ----------------------------------------------------------------------------
package pxa_pkg;

    // Size of the decided-value store and width of the kept value word.
    localparam int INSTANCE_DEPTH = 1024;
    localparam int VALUE_WIDTH    = 64;
    localparam int IDX_W          = $clog2(INSTANCE_DEPTH);
    localparam int MEM_W          = VALUE_WIDTH + 1;

    // Port field widths.
    localparam int KIND_W  = 2;
    localparam int INST_W  = 10;
    localparam int NUM_W   = 32;
    localparam int NODE_W  = 16;
    localparam int VALUE_W = 64;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_PREPARE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DECIDE  = 2'd2;

    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [INST_W-1:0]  inst_t;
    typedef logic [NUM_W-1:0]   num_t;
    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [VALUE_W-1:0] word_t;
    typedef logic [IDX_W-1:0]   idx_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_en;   // write one zero entry of the store sweep
        logic rd_en;    // capture the request and read the store
        logic exec_en;  // evaluate, update state and load the result register
    } pxa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last; // the sweep is at the last store entry
    } pxa_status_t;

    // One result item.
    typedef struct packed {
        logic  old_instance;
        logic  granted;
        logic  committed;
        num_t  acc_number;
        node_t acc_node;
        logic  value_present;
        word_t value_out;
    } pxa_result_t;

endpackage

FILE: design/pxa_if.sv
// ----------------------------------------------------------------------------
// pxa_if
// Valid/ready channels of the Paxos acceptor: the request channel and the
// result channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface pxa_req_if
    import pxa_pkg::*;
;
    logic  valid;
    logic  ready;
    kind_t kind;
    inst_t instance_req;
    num_t  prop_number;
    node_t prop_node;
    word_t value;

    modport source (
        output valid, kind, instance_req, prop_number, prop_node, value,
        input  ready
    );

    modport sink (
        input  valid, kind, instance_req, prop_number, prop_node, value,
        output ready
    );
endinterface

interface pxa_rsp_if
    import pxa_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  old_instance;
    logic  granted;
    logic  committed;
    num_t  acc_number;
    node_t acc_node;
    logic  value_present;
    word_t value_out;

    modport source (
        output valid, old_instance, granted, committed, acc_number, acc_node,
               value_present, value_out,
        input  ready
    );

    modport sink (
        input  valid, old_instance, granted, committed, acc_number, acc_node,
               value_present, value_out,
        output ready
    );
endinterface

FILE: design/pxa_ctrl.sv
// ----------------------------------------------------------------------------
// pxa_ctrl
// Controller of the Paxos acceptor: sweeps the store clear after reset,
// then steps each request through a capture cycle and an execute cycle,
// and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module pxa_ctrl
    import pxa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    input  pxa_status_t status,
    output pxa_cmd_t    cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        req_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The result register must be free, or freed in this cycle.
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.exec_en = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register occupancy.
    always_comb
    begin
        priority if (cmd.exec_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

FILE: design/pxa_dp.sv
// ----------------------------------------------------------------------------
// pxa_dp
// Datapath of the Paxos acceptor: request register, proposal and accepted
// state, decided-value store with its clearing counter, proposal compares
// and the result register.
// ----------------------------------------------------------------------------
module pxa_dp
    import pxa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pxa_cmd_t    cmd,
    output pxa_status_t status,
    input  logic        cfg_wr_en,
    input  node_t       cfg_wr_data,
    input  kind_t       kind,
    input  inst_t       instance_req,
    input  num_t        prop_number,
    input  node_t       prop_node,
    input  word_t       value,
    output pxa_result_t result
);

    // Configuration and acceptor state.
    node_t my_node_reg;
    num_t  prom_num_reg;
    node_t prom_node_reg;
    num_t  acc_num_reg;
    node_t acc_node_reg;
    logic [VALUE_WIDTH-1:0] acc_val_reg;
    logic  acc_pres_reg;
    inst_t high_dec_reg;

    // Captured request.
    kind_t kind_reg;
    inst_t inst_reg;
    num_t  num_reg;
    node_t node_reg;
    logic [VALUE_WIDTH-1:0] val_reg;

    // Store and its sweep counter.
    logic [MEM_W-1:0] mem [INSTANCE_DEPTH];
    logic [MEM_W-1:0] rd_data_reg;
    idx_t             clr_cnt_reg;
    idx_t             clr_cnt_next;
    logic             mem_we;
    idx_t             mem_waddr;
    logic [MEM_W-1:0] mem_wdata;

    logic        is_old;
    logic        prop_above;
    logic        prop_at_or_above;
    logic        do_promise;
    logic        do_accept;
    logic        do_commit;
    pxa_result_t res_next;
    pxa_result_t result_reg;

    // Proposal compares: number first, node id second.
    assign is_old           = (inst_reg <= high_dec_reg);
    assign prop_above       = (num_reg > prom_num_reg) ||
                              ((num_reg == prom_num_reg) && (node_reg > prom_node_reg));
    assign prop_at_or_above = (num_reg > prom_num_reg) ||
                              ((num_reg == prom_num_reg) && (node_reg >= prom_node_reg));

    assign do_promise = cmd.exec_en && (kind_reg == KIND_PREPARE) && !is_old && prop_above;
    assign do_accept  = cmd.exec_en && (kind_reg == KIND_ACCEPT) && !is_old && prop_at_or_above;
    assign do_commit  = cmd.exec_en && (kind_reg == KIND_DECIDE) && !is_old;

    // Result of the request held in the request register.
    always_comb
    begin
        res_next = '0;
        unique case (kind_reg)
            KIND_PREPARE:
            begin
                res_next.acc_number = acc_num_reg;
                res_next.acc_node   = acc_node_reg;
                if (is_old)
                begin
                    res_next.old_instance  = 1'b1;
                    res_next.value_present = rd_data_reg[VALUE_WIDTH];
                    res_next.value_out     = VALUE_W'(rd_data_reg[VALUE_WIDTH-1:0]);
                end
                else
                begin
                    res_next.granted       = prop_above;
                    res_next.value_present = acc_pres_reg;
                    res_next.value_out     = VALUE_W'(acc_val_reg);
                end
            end
            KIND_ACCEPT:
            begin
                res_next.granted = !is_old && prop_at_or_above;
            end
            KIND_DECIDE:
            begin
                res_next.committed = !is_old;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // Store write port: zero sweep after reset, decided value on commit.
    always_comb
    begin
        mem_we    = cmd.clr_en || do_commit;
        mem_waddr = cmd.clr_en ? clr_cnt_reg : inst_reg[IDX_W-1:0];
        mem_wdata = cmd.clr_en ? '0 : {1'b1, val_reg};
    end

    assign clr_cnt_next    = clr_cnt_reg + idx_t'(1);
    assign status.clr_last = (clr_cnt_reg == idx_t'(INSTANCE_DEPTH - 1));

    // Store array with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[instance_req[IDX_W-1:0]];
        end
    end

    // Sweep counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Request capture and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            kind_reg <= kind;
            inst_reg <= instance_req;
            num_reg  <= prop_number;
            node_reg <= prop_node;
            val_reg  <= value[VALUE_WIDTH-1:0];
        end
        if (cmd.exec_en)
        begin
            result_reg <= res_next;
        end
    end

    // Acceptor state and node id register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_node_reg   <= '0;
            prom_num_reg  <= '0;
            prom_node_reg <= '0;
            acc_num_reg   <= '0;
            acc_node_reg  <= '0;
            acc_val_reg   <= '0;
            acc_pres_reg  <= 1'b0;
            high_dec_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                my_node_reg <= cfg_wr_data;
            end
            priority if (do_commit)
            begin
                high_dec_reg  <= inst_reg;
                prom_num_reg  <= '0;
                prom_node_reg <= my_node_reg;
                acc_num_reg   <= '0;
                acc_node_reg  <= my_node_reg;
                acc_val_reg   <= '0;
                acc_pres_reg  <= 1'b0;
            end
            else if (do_promise)
            begin
                prom_num_reg  <= num_reg;
                prom_node_reg <= node_reg;
            end
            else if (do_accept)
            begin
                acc_num_reg  <= num_reg;
                acc_node_reg <= node_reg;
                acc_val_reg  <= val_reg;
                acc_pres_reg <= 1'b1;
            end
        end
    end

    assign result = result_reg;

endmodule

FILE: design/paxos_acceptor.sv
// ----------------------------------------------------------------------------
// paxos_acceptor
// Acceptor of per-instance Paxos: answers prepare, accept and decide
// requests and keeps a store of decided values.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Contents
//  request   in         valid / ready    kind, instance, proposal, value
//  result    out        valid / ready    flags, accepted proposal, value
//  cfg       in         cfg_wr_en        my_node_id (16 bits)
//
//  Each request passes through a capture cycle that issues the store read,
//  and an execute cycle that uses the registered read data, updates the
//  state and loads the result register.
//  After reset a clearing pass writes all 1024 store entries, one per cycle;
//  no request is taken during the clearing pass.
//  A full result register holds the execute cycle until the result transfer
//  completes; a new request is still taken while a result waits.
// ----------------------------------------------------------------------------
module paxos_acceptor
    import pxa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pxa_req_if.sink   request,
    pxa_rsp_if.source result,
    input  logic      cfg_wr_en,
    input  node_t     cfg_wr_data
);

    pxa_cmd_t    cmd;
    pxa_status_t status;
    pxa_result_t res;

    // Sequencing.
    pxa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .rsp_valid (result.valid),
        .rsp_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // State, store and result.
    pxa_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .kind         (request.kind),
        .instance_req (request.instance_req),
        .prop_number  (request.prop_number),
        .prop_node    (request.prop_node),
        .value        (request.value),
        .result       (res)
    );

    // Result payload.
    assign result.old_instance  = res.old_instance;
    assign result.granted       = res.granted;
    assign result.committed     = res.committed;
    assign result.acc_number    = res.acc_number;
    assign result.acc_node      = res.acc_node;
    assign result.value_present = res.value_present;
    assign result.value_out     = res.value_out;

endmodule
